// ===== rtl/bkht_pkg.sv =====
// Package for the byte key hash table: status codes, commands and sequencer states.
// Depends on nothing; used by every module of the block.
package bkht_pkg;

   localparam logic [1:0] CMD_GET    = 2'd0;
   localparam logic [1:0] CMD_FIND   = 2'd1;
   localparam logic [1:0] CMD_SET    = 2'd2;
   localparam logic [1:0] CMD_PREFIX = 2'd3;

   localparam logic [2:0] ST_FOUND     = 3'd0;
   localparam logic [2:0] ST_INSERTED  = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_TOO_LONG  = 3'd4;

   // Widths of the stored digest.
   localparam int HASH_W = 32;
   localparam int SUM_W  = 13;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIGEST,
      S_PROBE_RD,
      S_PROBE_CHK,
      S_CMP_RD,
      S_CMP_CHK,
      S_WRITE,
      S_KEY_WR,
      S_VAL_RD,
      S_RESULT
   } state_type;

endpackage

// ===== rtl/bkht_digest.sv =====
// Shared digest unit: one multiply-by-five-and-add step per cycle over the key buffer.
// Depends on bkht_pkg.
module bkht_digest
   import bkht_pkg::*;
(
   input  logic              clock,
   input  logic              start,
   input  logic              step,
   input  logic [7:0]        byte_in,
   output logic [HASH_W-1:0] hash,
   output logic [SUM_W-1:0]  sum
);

   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;

   // Hash is h*5 + byte mod 2^32; sum is a plain byte sum.
   always_comb begin
      hash_in = hash_ff;
      sum_in  = sum_ff;
      if (start) begin
         hash_in = '0;
         sum_in  = '0;
      end else if (step) begin
         hash_in = (hash_ff << 2) + hash_ff + HASH_W'(byte_in);
         sum_in  = sum_ff + SUM_W'(byte_in);
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
      sum_ff  <= sum_in;
   end

   assign hash = hash_ff;
   assign sum  = sum_ff;

endmodule

// ===== rtl/byte_key_hash_table.sv =====
// Top level of the byte key hash table: key buffer, slot stores and the probe sequencer.
// Depends on bkht_pkg and bkht_digest.
//
//  Channel | Direction | Fields
//  req     | in        | tdata: cmd, key_byte, new_value; tlast: key_last
//  rsp     | out       | tdata: status, slot, value, match_len
//
// Each key byte is written to the key buffer while the key fits. A final byte starts the
// digest over the buffered key, then each probed slot is read and checked, and so is each
// compared key byte, all through one digest unit and one key-byte memory port; an insert
// writes the slot and copies the key, then the value is read before the result beat is offered.
// A prefix lookup repeats the digest and the probes per length.
// Reset is synchronous and clears the valid map, the key count and the longest length.
// The request side is not ready while a command runs or a result waits to be taken.
module byte_key_hash_table
   import bkht_pkg::*;
#(
   parameter int SLOT_BITS     = 8,
   parameter int MAX_KEY_BYTES = 32,
   parameter int VALUE_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // cmd[1:0], key_byte[9:2], new_value[41:10], zero fill
   input  logic        req_tlast,  // key_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata   // status[2:0], slot[10:3], value[42:11], match_len[48:43]
);

   localparam int NSLOTS = 1 << SLOT_BITS;
   localparam int LEN_W  = $clog2(MAX_KEY_BYTES + 2);
   localparam int KB_W   = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int CNT_W  = SLOT_BITS + 1;

   // Request fields.
   logic [1:0]  req_cmd;
   logic [7:0]  req_key_byte;
   logic [31:0] req_new_value;
   assign req_cmd       = req_tdata[1:0];
   assign req_key_byte  = req_tdata[9:2];
   assign req_new_value = req_tdata[41:10];

   // Stores.
   logic                  valid_ff [NSLOTS];
   logic [HASH_W-1:0]     hash_mem [NSLOTS];
   logic [SUM_W-1:0]      sum_mem  [NSLOTS];
   logic [LEN_W-1:0]      len_mem  [NSLOTS];
   logic [VALUE_BITS-1:0] val_mem  [NSLOTS];
   logic [7:0]            kb_mem   [NSLOTS << KB_W];
   logic [7:0]            kbuf_mem [MAX_KEY_BYTES];

   state_type state_ff, state_in;
   logic [LEN_W-1:0]      count_ff, count_in;
   logic [LEN_W-1:0]      longest_ff, longest_in;
   logic [LEN_W-1:0]      len_ff, len_in;     // key length being probed
   logic [LEN_W-1:0]      idx_ff, idx_in;     // byte index
   logic [1:0]            cmd_ff, cmd_in;
   logic [VALUE_BITS-1:0] nv_ff, nv_in;
   logic [SLOT_BITS-1:0]  slot_ff, slot_in;
   logic [CNT_W-1:0]      tries_ff, tries_in;
   logic [2:0]            status_ff, status_in;
   logic [LEN_W-1:0]      mlen_ff, mlen_in;
   logic                  zero_val_ff, zero_val_in;
   logic                  write_val_ff, write_val_in;

   // Registered read data.
   logic                  rd_valid_ff;
   logic [HASH_W-1:0]     rd_hash_ff;
   logic [SUM_W-1:0]      rd_sum_ff;
   logic [LEN_W-1:0]      rd_len_ff;
   logic [VALUE_BITS-1:0] rd_val_ff;
   logic [7:0]            rd_kb_ff;
   logic [7:0]            rd_kbuf_ff;

   logic [HASH_W-1:0] dg_hash;
   logic [SUM_W-1:0]  dg_sum;
   logic              dg_start, dg_step;

   logic accept;
   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   // Key buffer read address: index in digest/compare, or slot key address.
   logic [KB_W-1:0] kidx;
   assign kidx = idx_ff[KB_W-1:0];
   logic [SLOT_BITS+KB_W-1:0] kb_addr;
   assign kb_addr = {slot_ff, kidx};

   // The key copy reads the buffer one byte ahead of the byte being written.
   logic [KB_W-1:0] kbuf_raddr;
   assign kbuf_raddr = (state_ff == S_KEY_WR) ? KB_W'(idx_ff + LEN_W'(1)) : kidx;

   bkht_digest u_digest (
      .clock  (clock),
      .start  (dg_start),
      .step   (dg_step),
      .byte_in(rd_kbuf_ff),
      .hash   (dg_hash),
      .sum    (dg_sum)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_tlast) begin
               if (count_ff >= LEN_W'(MAX_KEY_BYTES)) state_in = S_RESULT;
               else if (req_cmd == CMD_PREFIX && (longest_ff == '0)) state_in = S_RESULT;
               else state_in = S_DIGEST;
            end
         end
         S_DIGEST:    if (idx_ff == len_ff + LEN_W'(1)) state_in = S_PROBE_RD;
         S_PROBE_RD:  state_in = S_PROBE_CHK;
         S_PROBE_CHK: begin
            if (!rd_valid_ff) begin
               state_in = (cmd_ff == CMD_GET || cmd_ff == CMD_SET) ? S_WRITE : S_RESULT;
               if (cmd_ff == CMD_PREFIX && len_ff != LEN_W'(1)) state_in = S_DIGEST;
            end else if (rd_hash_ff == dg_hash && rd_sum_ff == dg_sum && rd_len_ff == len_ff)
               state_in = S_CMP_RD;
            else if (tries_ff == CNT_W'(NSLOTS - 1)) begin
               state_in = (cmd_ff == CMD_PREFIX && len_ff != LEN_W'(1)) ? S_DIGEST : S_RESULT;
            end else state_in = S_PROBE_RD;
         end
         S_CMP_RD:  state_in = S_CMP_CHK;
         S_CMP_CHK: begin
            if (rd_kb_ff != rd_kbuf_ff) begin
               if (tries_ff == CNT_W'(NSLOTS - 1))
                  state_in = (cmd_ff == CMD_PREFIX && len_ff != LEN_W'(1)) ? S_DIGEST : S_RESULT;
               else state_in = S_PROBE_RD;
            end else if (idx_ff + LEN_W'(1) == len_ff) state_in = S_VAL_RD;
            else state_in = S_CMP_RD;
         end
         S_WRITE:  state_in = S_KEY_WR;
         S_KEY_WR: if (idx_ff + LEN_W'(1) >= len_ff) state_in = S_VAL_RD;
         S_VAL_RD: state_in = S_RESULT;
         S_RESULT: if (rsp_tready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Datapath control.
   always_comb begin
      count_in     = count_ff;
      longest_in   = longest_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      cmd_in       = cmd_ff;
      nv_in        = nv_ff;
      slot_in      = slot_ff;
      tries_in     = tries_ff;
      status_in    = status_ff;
      mlen_in      = mlen_ff;
      zero_val_in  = zero_val_ff;
      write_val_in = write_val_ff;
      dg_start     = 1'b0;
      dg_step      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (count_ff <= LEN_W'(MAX_KEY_BYTES)) count_in = count_ff + LEN_W'(1);
               if (req_tlast) begin
                  count_in     = '0;
                  cmd_in       = req_cmd;
                  nv_in        = VALUE_BITS'(req_new_value);
                  idx_in       = '0;
                  dg_start     = 1'b1;
                  mlen_in      = '0;
                  zero_val_in  = 1'b0;
                  write_val_in = (req_cmd == CMD_SET);
                  status_in    = ST_NOT_FOUND;
                  len_in       = count_ff + LEN_W'(1);
                  if (count_ff >= LEN_W'(MAX_KEY_BYTES)) status_in = ST_TOO_LONG;
                  else if (req_cmd == CMD_PREFIX && longest_ff < count_ff + LEN_W'(1))
                     len_in = longest_ff;
               end
            end
         end
         S_DIGEST: begin
            // Buffer byte idx-1 is on the read register while 1 <= idx <= len.
            if (idx_ff != '0 && idx_ff != len_ff + LEN_W'(1)) dg_step = 1'b1;
            if (idx_ff == len_ff + LEN_W'(1)) begin
               idx_in   = '0;
               tries_in = '0;
               slot_in  = dg_hash[SLOT_BITS-1:0];
            end else idx_in = idx_ff + LEN_W'(1);
         end
         S_PROBE_RD: begin
            idx_in = '0;
         end
         S_PROBE_CHK: begin
            if (!rd_valid_ff) begin
               if (cmd_ff == CMD_PREFIX) begin
                  len_in = len_ff - LEN_W'(1);
                  idx_in = '0;
                  dg_start = 1'b1;
               end
            end else if (!(rd_hash_ff == dg_hash && rd_sum_ff == dg_sum
                           && rd_len_ff == len_ff)) begin
               if (tries_ff == CNT_W'(NSLOTS - 1)) begin
                  if (cmd_ff == CMD_PREFIX) begin
                     len_in = len_ff - LEN_W'(1);
                     idx_in = '0;
                     dg_start = 1'b1;
                  end else if (cmd_ff != CMD_FIND) status_in = ST_FULL;
               end else begin
                  tries_in = tries_ff + CNT_W'(1);
                  slot_in  = slot_ff + SLOT_BITS'(1);
               end
            end
         end
         S_CMP_CHK: begin
            if (rd_kb_ff != rd_kbuf_ff) begin
               idx_in = '0;
               if (tries_ff == CNT_W'(NSLOTS - 1)) begin
                  if (cmd_ff == CMD_PREFIX) begin
                     len_in = len_ff - LEN_W'(1);
                     dg_start = 1'b1;
                  end else if (cmd_ff != CMD_FIND) status_in = ST_FULL;
               end else begin
                  tries_in = tries_ff + CNT_W'(1);
                  slot_in  = slot_ff + SLOT_BITS'(1);
               end
            end else if (idx_ff + LEN_W'(1) == len_ff) begin
               status_in = ST_FOUND;
               if (cmd_ff == CMD_PREFIX) mlen_in = len_ff;
            end else idx_in = idx_ff + LEN_W'(1);
         end
         S_WRITE: begin
            status_in   = ST_INSERTED;
            zero_val_in = 1'b1;
            idx_in      = '0;
            if (len_ff > longest_ff) longest_in = len_ff;
         end
         S_KEY_WR: idx_in = idx_ff + LEN_W'(1);
         S_VAL_RD: begin
            zero_val_in  = 1'b0;
            write_val_in = 1'b0;
         end
         default: ;
      endcase
   end

   // Registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         longest_ff <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         longest_ff <= longest_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      idx_ff       <= idx_in;
      cmd_ff       <= cmd_in;
      nv_ff        <= nv_in;
      slot_ff      <= slot_in;
      tries_ff     <= tries_in;
      status_ff    <= status_in;
      mlen_ff      <= mlen_in;
      zero_val_ff  <= zero_val_in;
      write_val_ff <= write_val_in;
   end

   // Valid map.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSLOTS; i++) valid_ff[i] <= 1'b0;
      end else if (state_ff == S_WRITE) begin
         valid_ff[slot_ff] <= 1'b1;
      end
   end

   // Key buffer memory: written on accepted beats while the key fits, read at the byte index.
   always_ff @(posedge clock) begin
      if (accept && count_ff < LEN_W'(MAX_KEY_BYTES))
         kbuf_mem[count_ff[KB_W-1:0]] <= req_key_byte;
      rd_kbuf_ff <= kbuf_mem[kbuf_raddr];
   end

   // Slot stores; a value written in this cycle is passed straight to the read register.
   always_ff @(posedge clock) begin
      if (state_ff == S_WRITE) begin
         hash_mem[slot_ff] <= dg_hash;
         sum_mem[slot_ff]  <= dg_sum;
         len_mem[slot_ff]  <= len_ff;
      end
      if (state_ff == S_VAL_RD && (zero_val_ff || write_val_ff)) begin
         val_mem[slot_ff] <= write_val_ff ? nv_ff : '0;
         rd_val_ff        <= write_val_ff ? nv_ff : '0;
      end else begin
         rd_val_ff <= val_mem[slot_ff];
      end
      rd_valid_ff <= valid_ff[slot_ff];
      rd_hash_ff  <= hash_mem[slot_ff];
      rd_sum_ff   <= sum_mem[slot_ff];
      rd_len_ff   <= len_mem[slot_ff];
   end

   // Slot key bytes: copy from the buffer read register one byte a cycle.
   always_ff @(posedge clock) begin
      if (state_ff == S_KEY_WR) kb_mem[kb_addr] <= rd_kbuf_ff;
      rd_kb_ff <= kb_mem[kb_addr];
   end

   // Result beat.
   logic              ok;
   logic [7:0]        o_slot;
   logic [31:0]       o_val;
   assign ok     = (status_ff == ST_FOUND || status_ff == ST_INSERTED);
   assign o_slot = ok ? 8'(slot_ff) : 8'd0;
   assign o_val  = ok ? 32'(rd_val_ff) : 32'd0;

   assign rsp_tvalid = (state_ff == S_RESULT);
   assign rsp_tdata  = {7'd0, 6'(mlen_ff), o_val, o_slot, status_ff};

endmodule
